### rtl/core/json_syntax_check_assert.svh
// ----------------------------------------------------------------------------
// json_syntax_check assertion macros
// Shared assertion forms for the syntax checker's verification collateral.
// ----------------------------------------------------------------------------
`ifndef JSON_SYNTAX_CHECK_ASSERT_SVH
`define JSON_SYNTAX_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("json_syntax_check: assertion failed");

// next-cycle implication, disabled during reset
`define JSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("json_syntax_check: assertion failed");

`endif

### rtl/core/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Types, character codes and literal tables for the JSON syntax checker.
// ----------------------------------------------------------------------------
package jsc_pkg;

	typedef enum logic [3:0] {
		PH_VALUE     = 4'd0,
		PH_AFTER     = 4'd1,
		PH_OBJ_FIRST = 4'd2,
		PH_OBJ_KEY   = 4'd3,
		PH_KEY_STR   = 4'd4,
		PH_KEY_ESC   = 4'd5,
		PH_COLON     = 4'd6,
		PH_ARR_FIRST = 4'd7,
		PH_STR       = 4'd8,
		PH_STR_ESC   = 4'd9,
		PH_NUMBER    = 4'd10,
		PH_LITERAL   = 4'd11
	} phase_t;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;

	localparam logic [6:0] MAX_NESTING_RST = 7'd64;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] lit_kind;
		logic [2:0] lit_pos;
		logic       failed;
		logic       overflowed;
	} parse_st_t;

	localparam parse_st_t PARSE_RST = '{
		phase: PH_VALUE, lit_kind: LIT_TRUE, lit_pos: 3'd0,
		failed: 1'b0, overflowed: 1'b0};

	typedef struct packed {
		logic push;
		logic pop;
		logic kind;   // 1 = object, 0 = array
	} stk_op_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic top_obj;
	} stk_stat_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h65 ||
			c == 8'h45 || c == 8'h2B || c == 8'h2D;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (kind)
			LIT_FALSE: begin
				case (pos)
					3'd0: ch = 8'h66;
					3'd1: ch = 8'h61;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h73;
					3'd4: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (pos)
					3'd0: ch = 8'h6E;
					3'd1: ch = 8'h75;
					3'd2: ch = 8'h6C;
					3'd3: ch = 8'h6C;
					default: ch = 8'h00;
				endcase
			end
			default: begin
				// true, also for the unused kind code
				case (pos)
					3'd0: ch = 8'h74;
					3'd1: ch = 8'h72;
					3'd2: ch = 8'h75;
					3'd3: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

### rtl/core/jsc_step.sv
// ----------------------------------------------------------------------------
// jsc_step
// One-byte parser transition: next parse state and the stack push or pop.
// ----------------------------------------------------------------------------
module jsc_step import jsc_pkg::*; (
	input  logic       en,
	input  logic [7:0] text_byte,
	input  parse_st_t  st,
	input  stk_stat_t  stat,
	output parse_st_t  nxt,
	output stk_op_t    op
);

	phase_t     ph1;
	phase_t     ph2;
	logic       ws;
	logic       starter;
	logic [1:0] kind;
	logic [2:0] pos_inc;

	always_comb begin
		ws      = is_ws(text_byte);
		starter = text_byte == CH_QUOTE || text_byte == CH_LBRACE ||
			text_byte == CH_LBRACK || text_byte == CH_T || text_byte == CH_F ||
			text_byte == CH_N || is_num(text_byte);
		kind    = (st.lit_kind == LIT_FALSE || st.lit_kind == LIT_NULL) ?
			st.lit_kind : LIT_TRUE;
		pos_inc = st.lit_pos + 3'd1;

		// resolve the re-dispatch chain: first array slot -> value -> after
		ph1 = (st.phase == PH_ARR_FIRST && !ws && text_byte != CH_RBRACK) ?
			PH_VALUE : st.phase;
		ph2 = ((ph1 == PH_VALUE && !ws && !starter) ||
			(ph1 == PH_NUMBER && !is_num(text_byte))) ? PH_AFTER : ph1;

		nxt = st;
		op  = '{push: 1'b0, pop: 1'b0, kind: 1'b0};

		if (en && !st.failed) begin
			// the re-dispatched phase stands unless a branch below moves it
			nxt.phase = ph2;
			case (ph2)
				PH_VALUE: begin
					if (text_byte == CH_QUOTE) begin
						nxt.phase = PH_STR;
					end else if (text_byte == CH_LBRACE || text_byte == CH_LBRACK) begin
						if (stat.full) begin
							nxt.overflowed = 1'b1;
							nxt.failed     = 1'b1;
						end else begin
							op.push   = 1'b1;
							op.kind   = text_byte == CH_LBRACE;
							nxt.phase = (text_byte == CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
						end
					end else if (text_byte == CH_T || text_byte == CH_F || text_byte == CH_N) begin
						nxt.lit_kind = (text_byte == CH_T) ? LIT_TRUE :
							((text_byte == CH_F) ? LIT_FALSE : LIT_NULL);
						nxt.lit_pos  = 3'd1;
						nxt.phase    = PH_LITERAL;
					end else if (is_num(text_byte)) begin
						nxt.phase = PH_NUMBER;
					end
				end
				PH_AFTER: begin
					if (!ws) begin
						if (stat.empty) begin
							nxt.failed = 1'b1;
						end else if (text_byte == CH_COMMA) begin
							nxt.phase = stat.top_obj ? PH_OBJ_KEY : PH_VALUE;
						end else if (text_byte == (stat.top_obj ? CH_RBRACE : CH_RBRACK)) begin
							op.pop    = 1'b1;
							nxt.phase = PH_AFTER;
						end else begin
							nxt.failed = 1'b1;
						end
					end
				end
				PH_OBJ_FIRST: begin
					if (!ws) begin
						if (text_byte == CH_RBRACE) begin
							op.pop    = 1'b1;
							nxt.phase = PH_AFTER;
						end else if (text_byte == CH_QUOTE) begin
							nxt.phase = PH_KEY_STR;
						end else begin
							nxt.failed = 1'b1;
						end
					end
				end
				PH_OBJ_KEY: begin
					if (!ws) begin
						if (text_byte == CH_QUOTE)
							nxt.phase = PH_KEY_STR;
						else
							nxt.failed = 1'b1;
					end
				end
				PH_KEY_STR: begin
					if (text_byte == CH_BSLASH)
						nxt.phase = PH_KEY_ESC;
					else if (text_byte == CH_QUOTE)
						nxt.phase = PH_COLON;
				end
				PH_KEY_ESC: begin
					nxt.phase = PH_KEY_STR;
				end
				PH_COLON: begin
					if (!ws) begin
						if (text_byte == CH_COLON)
							nxt.phase = PH_VALUE;
						else
							nxt.failed = 1'b1;
					end
				end
				PH_ARR_FIRST: begin
					// only whitespace or the closing bracket reach here
					if (text_byte == CH_RBRACK) begin
						op.pop    = 1'b1;
						nxt.phase = PH_AFTER;
					end
				end
				PH_STR: begin
					if (text_byte == CH_BSLASH)
						nxt.phase = PH_STR_ESC;
					else if (text_byte == CH_QUOTE)
						nxt.phase = PH_AFTER;
				end
				PH_STR_ESC: begin
					nxt.phase = PH_STR;
				end
				PH_NUMBER: begin
					nxt.phase = PH_NUMBER;
				end
				PH_LITERAL: begin
					if (st.lit_pos < lit_len(kind) && text_byte == lit_char(kind, st.lit_pos)) begin
						nxt.lit_pos = pos_inc;
						if (pos_inc >= lit_len(kind))
							nxt.phase = PH_AFTER;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				default: begin
					nxt.failed = 1'b1;
				end
			endcase
		end
	end

endmodule

### rtl/core/jsc_stack.sv
// ----------------------------------------------------------------------------
// jsc_stack
// Container-kind stack as a shift line with the nesting level and limit check.
// ----------------------------------------------------------------------------
module jsc_stack import jsc_pkg::*; #(
	parameter int MAX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  stk_op_t    op,
	input  logic [6:0] max_nesting,
	output stk_stat_t  stat,
	output logic       empty_nxt
);

	localparam int LW = $clog2(MAX_DEPTH + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	logic [MAX_DEPTH-1:0] stk_q;   // entry 0 is the top
	logic [LW-1:0]        level_q;
	logic [CW-1:0]        limit;
	logic                 do_push;
	logic                 do_pop;

	assign limit = (CW'(max_nesting) > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(max_nesting);

	assign stat.empty   = level_q == '0;
	assign stat.full    = CW'(level_q) >= limit;
	assign stat.top_obj = !stat.empty && stk_q[0];

	assign do_push = op.push && !stat.full;
	assign do_pop  = op.pop && !stat.empty;

	assign empty_nxt = (stat.empty && !do_push) || (level_q == LW'(1) && do_pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (clear) begin
			level_q <= '0;
		end else if (do_push) begin
			level_q <= level_q + LW'(1);
		end else if (do_pop) begin
			level_q <= level_q - LW'(1);
		end
	end

	// entries below the level are never read before being pushed
	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_ent
		logic shin;
		logic shout;
		if (i == 0) begin : g_top
			assign shin = op.kind;
		end else begin : g_mid
			assign shin = stk_q[i-1];
		end
		if (i == MAX_DEPTH - 1) begin : g_bot
			assign shout = 1'b0;
		end else begin : g_up
			assign shout = stk_q[i+1];
		end
		always_ff @(posedge clk) begin
			if (do_push)
				stk_q[i] <= shin;
			else if (do_pop)
				stk_q[i] <= shout;
		end
	end

endmodule

### rtl/core/json_syntax_check.sv
// ----------------------------------------------------------------------------
// json_syntax_check
// Streaming syntax check of one lenient JSON message, one byte per request.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle and, on the byte marked is_last,
// delivers one result: is_valid when the message is a single value followed
// only by whitespace, too_deep when a container was opened past max_nesting
// (capped at MAX_DEPTH). A byte waits in the input register; its state
// transition and stack push or pop complete as it leaves, so the sustained
// rate is one byte per cycle unless stalled; the result register loads as the
// last byte leaves. The input stalls only while a finished result waits on a
// stalled output and the next last byte is ready behind it. The user writes
// max_nesting through the always-ready configuration channel between messages;
// the block does not enforce this. It resets to 64 and is kept across messages.
module json_syntax_check import jsc_pkg::*; #(
	parameter int MAX_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] max_nesting,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       is_last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       is_valid,
	output logic       too_deep
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [6:0] max_nesting_q;
	parse_st_t  st_q;
	parse_st_t  st_nxt;
	stk_op_t    op;
	stk_stat_t  stat;
	logic       empty_nxt;
	logic       advance;
	logic       valid_q;
	logic       is_valid_q;
	logic       too_deep_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_nesting_q <= MAX_NESTING_RST;
		else if (cfg_valid)
			max_nesting_q <= max_nesting;
	end

	// a last byte waits only if the result register is full and held
	assign advance    = valid_s1 && !(last_s1 && valid_q && result_stall);
	assign text_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	jsc_step u_step (
		.en        (advance),
		.text_byte (byte_s1),
		.st        (st_q),
		.stat      (stat),
		.nxt       (st_nxt),
		.op        (op)
	);

	jsc_stack #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (advance && last_s1),
		.op          (op),
		.max_nesting (max_nesting_q),
		.stat        (stat),
		.empty_nxt   (empty_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RST;
		end else if (advance) begin
			st_q <= last_s1 ? PARSE_RST : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			is_valid_q <= !st_nxt.failed && empty_nxt &&
				(st_nxt.phase == PH_AFTER || st_nxt.phase == PH_NUMBER);
			too_deep_q <= st_nxt.overflowed;
		end
	end

	assign result_valid = valid_q;
	assign is_valid     = is_valid_q;
	assign too_deep     = too_deep_q;

endmodule

### rtl/core/jsc_checker.sv
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks for json_syntax_check, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_syntax_check_assert.svh"

module jsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_stall,
	input logic [7:0] text_byte,
	input logic       is_last,
	input logic       result_valid,
	input logic       result_stall,
	input logic       is_valid,
	input logic       too_deep
);

	// a held result keeps its payload
	`JSC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(is_valid) && $stable(too_deep))

	// an overflowed message never passes
	`JSC_ASSERT_IMPL(a_deep_invalid, clk, arst_n, result_valid && too_deep, !is_valid)

	// input backpressure comes only from a held result
	`JSC_ASSERT_IMPL(a_stall_cause, clk, arst_n, text_stall, result_valid && result_stall)

	// a stalled request stays offered with the same byte
	`JSC_ASSERT_NEXT(a_req_hold, clk, arst_n, text_valid && text_stall, text_valid && $stable(text_byte) && $stable(is_last))

endmodule

bind json_syntax_check jsc_checker u_jsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_valid   (text_valid),
	.text_stall   (text_stall),
	.text_byte    (text_byte),
	.is_last      (is_last),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.is_valid     (is_valid),
	.too_deep     (too_deep)
);
